>>> rtl/lobm_pkg.sv
// Shared types and constants for the limit order book matcher.
// No dependencies; imported by lobm_cell and limit_order_book_matcher.
package lobm_pkg;

  localparam int SIZE_W   = 16;
  localparam int PRICE_W  = 17;
  localparam int LEVEL_W  = 22;
  localparam int CID_W    = 7;
  localparam int IN_W     = 48;
  localparam int OUT_W    = 112;
  localparam int TCNT_W   = 6;

  localparam logic [PRICE_W-1:0] NO_ASK_PRICE = PRICE_W'(99999);
  localparam logic [TCNT_W-1:0]  MAX_TRADES   = TCNT_W'(63);

  typedef enum logic [1:0] {
    OP_BUY    = 2'd0,
    OP_SELL   = 2'd1,
    OP_CANCEL = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    SIDE_NONE = 2'd0,
    SIDE_BUY  = 2'd1,
    SIDE_SELL = 2'd2
  } side_t;

  localparam logic KIND_TRADE = 1'b0;
  localparam logic KIND_QUOTE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CANCEL,
    ST_SCAN,
    ST_TRADE,
    ST_QUOTE
  } state_t;

  // Write command broadcast along the chain; slot index travels beside it.
  typedef struct packed {
    logic               en;
    logic               full_wr;  // 1: side, rem and price; 0: rem only
    side_t              side;
    logic [SIZE_W-1:0]  rem;
    logic [PRICE_W-1:0] px;
  } cmd_t;

  // Best-so-far token handed from cell to cell for one side.
  typedef struct packed {
    logic               found;
    logic [PRICE_W-1:0] px;
    logic [SIZE_W-1:0]  rem;
    logic [LEVEL_W-1:0] sum;
  } tok_t;

endpackage

>>> rtl/lobm_cell.sv
// One order slot of the book plus its stage of the best-price scan chain.
// Depends on lobm_pkg.
module lobm_cell #(
  parameter int IDX = 0,
  parameter int SW  = 6,
  parameter int IW  = 7
) (
  input  logic                  clk,
  input  lobm_pkg::cmd_t        cmd,
  input  logic [SW-1:0]         cmd_slot,
  input  logic [IW-1:0]         next_id,
  input  lobm_pkg::tok_t        bid_in,
  input  logic [SW-1:0]         bid_slot_in,
  input  lobm_pkg::tok_t        ask_in,
  input  logic [SW-1:0]         ask_slot_in,
  output lobm_pkg::tok_t        bid_out,
  output logic [SW-1:0]         bid_slot_out,
  output lobm_pkg::tok_t        ask_out,
  output logic [SW-1:0]         ask_slot_out
);
  import lobm_pkg::*;

  side_t               side;
  logic [SIZE_W-1:0]   rem;
  logic [PRICE_W-1:0]  px;
  logic                used;
  tok_t                bid_next, ask_next;
  logic [SW-1:0]       bid_slot_next, ask_slot_next;
  logic [LEVEL_W:0]    bid_add, ask_add;

  always_ff @(posedge clk) begin
    if (cmd.en && cmd_slot == SW'(IDX)) begin
      rem <= cmd.rem;
      if (cmd.full_wr) begin
        side <= cmd.side;
        px   <= cmd.px;
      end
    end
  end

  assign used    = IW'(IDX) < next_id;
  assign bid_add = {1'b0, bid_in.sum} + (LEVEL_W+1)'(rem);
  assign ask_add = {1'b0, ask_in.sum} + (LEVEL_W+1)'(rem);

  // Keep the earliest order of the best price; add same-price size to the level.
  always_comb begin
    bid_next      = bid_in;
    bid_slot_next = bid_slot_in;
    if (used && side == SIDE_BUY) begin
      if (rem != '0 && (!bid_in.found || px > bid_in.px)) begin
        bid_next.found = 1'b1;
        bid_next.px    = px;
        bid_next.rem   = rem;
        bid_next.sum   = LEVEL_W'(rem);
        bid_slot_next  = SW'(IDX);
      end else if (bid_in.found && px == bid_in.px) begin
        bid_next.sum = bid_add[LEVEL_W] ? '1 : bid_add[LEVEL_W-1:0];
      end
    end
  end

  always_comb begin
    ask_next      = ask_in;
    ask_slot_next = ask_slot_in;
    if (used && side == SIDE_SELL) begin
      if (rem != '0 && (!ask_in.found || px < ask_in.px)) begin
        ask_next.found = 1'b1;
        ask_next.px    = px;
        ask_next.rem   = rem;
        ask_next.sum   = LEVEL_W'(rem);
        ask_slot_next  = SW'(IDX);
      end else if (ask_in.found && px == ask_in.px) begin
        ask_next.sum = ask_add[LEVEL_W] ? '1 : ask_add[LEVEL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    bid_out      <= bid_next;
    bid_slot_out <= bid_slot_next;
    ask_out      <= ask_next;
    ask_slot_out <= ask_slot_next;
  end

endmodule

>>> rtl/limit_order_book_matcher.sv
// Limit order book, price-time priority, built as a chain of ORDER_SLOTS cells.
// A buy or sell scans the chain once per fill, once more to rest its remainder and once
// for the quote, plus the transfers; a cancel, clear or ignored item scans only once.
// One item at a time: a new item is accepted only in the idle state.
// Reset: rst clears the control state and the id counter; slot contents are kept.
module limit_order_book_matcher #(
  parameter int ORDER_SLOTS = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // op[1:0], size[17:2], price[34:18], cancel_id[41:35], zero fill above
  input  logic [lobm_pkg::IN_W-1:0]  s_tdata,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // trade_size[15:0], trade_price[32:16], bid_size[54:33], bid_price[71:55],
  // ask_size[93:72], ask_price[110:94], zero fill above
  output logic [lobm_pkg::OUT_W-1:0] m_tdata,
  // kind[0]
  output logic                     m_tuser,
  output logic                     m_tlast
);
  import lobm_pkg::*;

  localparam int SW   = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
  localparam int IW   = $clog2(ORDER_SLOTS + 1);
  localparam int CW   = $clog2(ORDER_SLOTS + 2);
  localparam int CMPW = (IW > CID_W) ? IW : CID_W;

  // Input fields.
  op_t                in_op;
  logic [SIZE_W-1:0]  in_size;
  logic [PRICE_W-1:0] in_price;
  logic [CID_W-1:0]   in_cid;

  assign in_op    = op_t'(s_tdata[1:0]);
  assign in_size  = s_tdata[17:2];
  assign in_price = s_tdata[34:18];
  assign in_cid   = s_tdata[41:35];

  // Control registers.
  state_t             state, state_next;
  logic [IW-1:0]      next_id;
  logic [CW-1:0]      scan_cnt;
  logic               match_phase;
  logic               is_buy;
  logic [PRICE_W-1:0] limit_px;
  logic [SIZE_W-1:0]  rem_r;
  logic [SW-1:0]      me;
  logic [CID_W-1:0]   cid_r;
  logic [IW-1:0]      me_cnt;
  logic [TCNT_W-1:0]  trade_cnt;

  // Chain.
  tok_t               bid_tok  [ORDER_SLOTS+1];
  tok_t               ask_tok  [ORDER_SLOTS+1];
  logic [SW-1:0]      bid_slot [ORDER_SLOTS+1];
  logic [SW-1:0]      ask_slot [ORDER_SLOTS+1];
  cmd_t               cmd;
  logic [SW-1:0]      cmd_slot;

  // Decision signals.
  logic               accept, full, scan_done, crossing, emit_trade, cid_ok;
  tok_t               opp;
  logic [SW-1:0]      opp_slot;
  logic [SIZE_W-1:0]  fill;
  tok_t               best_bid, best_ask;

  function automatic logic [CMPW-1:0] in_cid_ext(input logic [CID_W-1:0] c);
    return CMPW'(c);
  endfunction

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign full      = (next_id == IW'(ORDER_SLOTS));
  assign scan_done = (scan_cnt == CW'(ORDER_SLOTS + 1));
  assign best_bid  = bid_tok[ORDER_SLOTS];
  assign best_ask  = ask_tok[ORDER_SLOTS];
  assign opp       = is_buy ? best_ask : best_bid;
  assign opp_slot  = is_buy ? ask_slot[ORDER_SLOTS] : bid_slot[ORDER_SLOTS];
  assign crossing  = (rem_r != '0) && opp.found &&
                     (is_buy ? (opp.px <= limit_px) : (opp.px >= limit_px));
  assign fill      = (opp.rem < rem_r) ? opp.rem : rem_r;
  assign emit_trade = (trade_cnt < MAX_TRADES);
  assign cid_ok    = (in_cid_ext(cid_r) >= CMPW'(1)) &&
                     (in_cid_ext(cid_r) <= CMPW'(me_cnt));

  // Seed the chain with empty tokens.
  assign bid_tok[0]  = '0;
  assign ask_tok[0]  = '0;
  assign bid_slot[0] = '0;
  assign ask_slot[0] = '0;

  for (genvar i = 0; i < ORDER_SLOTS; i++) begin : g_cell
    lobm_cell #(.IDX(i), .SW(SW), .IW(IW)) u_cell (
      .clk          (clk),
      .cmd          (cmd),
      .cmd_slot     (cmd_slot),
      .next_id      (next_id),
      .bid_in       (bid_tok[i]),
      .bid_slot_in  (bid_slot[i]),
      .ask_in       (ask_tok[i]),
      .ask_slot_in  (ask_slot[i]),
      .bid_out      (bid_tok[i+1]),
      .bid_slot_out (bid_slot[i+1]),
      .ask_out      (ask_tok[i+1]),
      .ask_slot_out (ask_slot[i+1])
    );
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_op == OP_CANCEL && !full) state_next = ST_CANCEL;
          else                             state_next = ST_SCAN;
        end
      end
      ST_CANCEL: state_next = ST_SCAN;
      ST_SCAN: begin
        if (scan_done) begin
          if (!match_phase)                 state_next = ST_QUOTE;
          else if (crossing && emit_trade)  state_next = ST_TRADE;
        end
      end
      ST_TRADE: if (m_tready) state_next = ST_SCAN;
      ST_QUOTE: if (m_tready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Write command into the chain.
  always_comb begin
    cmd      = '0;
    cmd_slot = me;
    case (state)
      ST_IDLE: begin
        // Claim the new slot as an empty entry before anything else reads it.
        if (accept && !full && (in_op == OP_BUY || in_op == OP_SELL ||
                                in_op == OP_CANCEL)) begin
          cmd.en      = 1'b1;
          cmd.full_wr = 1'b1;
          cmd.side    = SIDE_NONE;
          cmd_slot    = next_id[SW-1:0];
        end
      end
      ST_CANCEL: begin
        cmd.en   = cid_ok;
        cmd_slot = SW'(cid_r - CID_W'(1));
      end
      ST_SCAN: begin
        if (scan_done && match_phase) begin
          cmd.en = 1'b1;
          if (crossing) begin
            cmd.rem  = opp.rem - fill;
            cmd_slot = opp_slot;
          end else begin
            // Rest the remainder in the book.
            cmd.full_wr = 1'b1;
            cmd.side    = is_buy ? SIDE_BUY : SIDE_SELL;
            cmd.rem     = rem_r;
            cmd.px      = limit_px;
          end
        end
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      next_id   <= '0;
      scan_cnt  <= '0;
      m_tvalid  <= 1'b0;
      trade_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_SCAN && !scan_done) scan_cnt <= scan_cnt + CW'(1);
      else                                scan_cnt <= '0;
      if (accept) begin
        trade_cnt <= '0;
        if (in_op == OP_CLEAR)  next_id <= '0;
        else if (!full)         next_id <= next_id + IW'(1);
      end
      if (state == ST_SCAN && scan_done) begin
        if (match_phase && crossing && emit_trade) begin
          m_tvalid  <= 1'b1;
          trade_cnt <= trade_cnt + TCNT_W'(1);
        end else if (!match_phase) begin
          m_tvalid <= 1'b1;
        end
      end
      if ((state == ST_TRADE || state == ST_QUOTE) && m_tready) m_tvalid <= 1'b0;
    end
  end

  // Item context and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      is_buy      <= (in_op == OP_BUY);
      limit_px    <= in_price;
      rem_r       <= in_size;
      me          <= next_id[SW-1:0];
      me_cnt      <= next_id;
      cid_r       <= in_cid;
      match_phase <= !full && (in_op == OP_BUY || in_op == OP_SELL);
    end
    if (state == ST_SCAN && scan_done) begin
      if (match_phase) begin
        if (crossing) begin
          rem_r <= rem_r - fill;
          if (emit_trade) begin
            m_tuser <= KIND_TRADE;
            m_tlast <= 1'b0;
            m_tdata <= {1'b0, 78'd0, opp.px, fill};
          end
        end else begin
          match_phase <= 1'b0;
        end
      end else begin
        m_tuser <= KIND_QUOTE;
        m_tlast <= 1'b1;
        m_tdata <= {1'b0,
                    best_ask.found ? best_ask.px  : NO_ASK_PRICE,
                    best_ask.found ? best_ask.sum : LEVEL_W'(0),
                    best_bid.found ? best_bid.px  : PRICE_W'(0),
                    best_bid.found ? best_bid.sum : LEVEL_W'(0),
                    PRICE_W'(0), SIZE_W'(0)};
      end
    end
  end

endmodule
